// ===== sv/keyboard_matrix_event_queue_unit_macros.svh =====
// Assertion macros for the keyboard matrix event queue unit.
// No dependencies; the including module supplies clk and rst_n.
`ifndef KEYBOARD_MATRIX_EVENT_QUEUE_UNIT_MACROS_SVH
`define KEYBOARD_MATRIX_EVENT_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KMEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMEQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KMEQ_ASSERT(lbl, prop, msg)
`define KMEQ_NEVER(lbl, expr, msg)
`endif
`endif

// ===== sv/kmeq_pkg.sv =====
// Shared constants, types and key map for the keyboard matrix event queue.
// No dependencies.
package kmeq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int TAP_TICKS   = 6;
  localparam int TAP_W       = 3;
  localparam int CYC_W       = 32;

  localparam logic [2:0] CMD_KEY   = 3'd0;
  localparam logic [2:0] CMD_TAP   = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] M_NEUTRAL = 2'd0;
  localparam logic [1:0] M_SHIFT   = 2'd1;
  localparam logic [1:0] M_NOSHIFT = 2'd2;
  localparam logic [1:0] M_PERSIST = 2'd3;

  localparam logic [1:0] K_KEY   = 2'd0;
  localparam logic [1:0] K_MODE  = 2'd1;
  localparam logic [1:0] K_ALLUP = 2'd2;

  localparam logic [1:0] REG_STRETCH = 2'd0;
  localparam logic [1:0] REG_TURBO   = 2'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  code;
    logic        rel;
    logic [7:0]  addr;
    logic [31:0] cyc;
    logic        mapped;
    logic [5:0]  key;
    logic [1:0]  mode;
  } item_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

  // {mapped, mode, key}
  function automatic logic [8:0] map_code(input logic [7:0] c);
    logic [5:0] k;
    logic [1:0] m;
    logic       v;
    k = 6'd0;
    m = M_NEUTRAL;
    v = 1'b1;
    if (c == 8'h08) k = 6'd53;
    else if (c == 8'h0c) k = 6'd49;
    else if (c == 8'h0d) k = 6'd48;
    else if (c == 8'h1b) k = 6'd50;
    else if (c == 8'h20) k = 6'd55;
    else if (c >= 8'h21 && c <= 8'h2b) begin
      k = 6'(c - 8'h21 + 8'd33); m = M_SHIFT;
    end else if (c >= 8'h2c && c <= 8'h2f) begin
      k = 6'(c - 8'h2c + 8'd44); m = M_NOSHIFT;
    end else if (c >= 8'h30 && c <= 8'h3b) begin
      k = 6'(c - 8'h30 + 8'd32); m = M_NOSHIFT;
    end else if (c >= 8'h3c && c <= 8'h3f) begin
      k = 6'(c - 8'h3c + 8'd44); m = M_SHIFT;
    end else if (c >= 8'h40 && c <= 8'h5f) begin
      k = 6'(c - 8'h40);
      m = (c >= 8'h41 && c <= 8'h5a) ? M_SHIFT : M_NOSHIFT;
    end else if (c >= 8'h60 && c <= 8'h7e) begin
      k = 6'(c - 8'h60);
      m = (c >= 8'h61 && c <= 8'h7a) ? M_NOSHIFT : M_SHIFT;
    end else v = 1'b0;
    return {v, m, k};
  endfunction

  function automatic logic [7:0] force_row7(input logic [7:0] v, input logic [1:0] mode);
    logic [7:0] r;
    r = v;
    if (mode == M_NOSHIFT) r = v & 8'hfc;
    else if (mode != M_NEUTRAL && v[1:0] == 2'b00) r = v | 8'h01;
    return r;
  endfunction

endpackage

// ===== sv/kmeq_front.sv =====
// Front end: input handshake, one-item holding stage and key-code classification.
// Depends on kmeq_pkg.
module kmeq_front import kmeq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic        in_key_released,
  input  logic [7:0]  in_read_address,
  input  logic [31:0] in_cycle_count,
  input  logic        take,
  output logic        item_vld,
  output item_t       item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic [8:0] mc;

  assign in_ready = !vld_r || take;
  assign item_vld = vld_r;
  assign item     = item_r;
  assign mc       = map_code(in_char_code);

  always_comb begin
    vld_nxt = vld_r;
    if (take) vld_nxt = 1'b0;
    if (in_valid && in_ready) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cmd    <= in_command;
      item_r.code   <= in_char_code;
      item_r.rel    <= in_key_released;
      item_r.addr   <= in_read_address;
      item_r.cyc    <= in_cycle_count;
      item_r.mapped <= mc[8];
      item_r.mode   <= mc[7:6];
      item_r.key    <= mc[5:0];
    end
  end

endmodule

// ===== sv/kmeq_actq.sv =====
// Action queue storage: one write port, one read port with registered data.
// Depends on kmeq_pkg.
module kmeq_actq import kmeq_pkg::*; (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [QW-1:0] wr_addr,
  input  logic [9:0]    wr_data,
  input  logic          rd_en,
  input  logic [QW-1:0] rd_addr,
  output logic [9:0]    rd_data
);

  logic [9:0] mem [QUEUE_DEPTH];
  logic [9:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== sv/kmeq_back.sv =====
// Back end: command sequencer, queue pointers, matrix, tap and read logic.
// Depends on kmeq_pkg and kmeq_actq.
module kmeq_back import kmeq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_vld,
  input  item_t       item,
  output logic        take,
  input  logic [31:0] stretch,
  input  logic [7:0]  turbo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_keypress_level,
  output bk_stat_t    stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENQ2  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DL    = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  item_t            itm_r, itm_nxt;
  logic [QW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       rows_r [8];
  logic [7:0]       rows_nxt [8];
  logic [1:0]       sfm_r, sfm_nxt;
  logic [6:0]       prs_r, prs_nxt;
  logic [1:0]       tick_r, tick_nxt;
  logic [CYC_W-1:0] dl_r, dl_nxt;
  logic             tapv_r, tapv_nxt;
  logic [5:0]       tapk_r, tapk_nxt;
  logic [1:0]       tapm_r, tapm_nxt;
  logic [TAP_W-1:0] tapt_r, tapt_nxt;
  logic [1:0]       last_r, last_nxt;
  logic [7:0]       kp_r, kp_nxt;
  logic [9:0]       a2_r, a2_nxt;
  logic             pend_r;
  logic             ov_r;
  logic [7:0]       ord_r, okp_r;

  logic             wr_en, rd_en;
  logic [9:0]       wr_data, rd_data;
  logic [SUM_W-1:0] tsum;
  logic [QW-1:0]    tail, head_inc;
  logic [7:0]       lvl;
  logic [CYC_W-1:0] cyc, diff;
  logic [7:0]       rdv;
  logic [TAP_W-1:0] tdec;
  logic [2:0]       arow, abit;
  logic             adown, awas;
  logic             out_free;

  kmeq_actq u_actq (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign tsum     = SUM_W'(head_r) + SUM_W'(cnt_r);
  assign tail     = (tsum >= SUM_W'(QUEUE_DEPTH)) ? QW'(tsum - SUM_W'(QUEUE_DEPTH)) : QW'(tsum);
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign lvl      = (turbo != 8'd0) ? turbo : 8'd1;
  assign cyc      = CYC_W'(itm_r.cyc);
  assign diff     = dl_r - cyc;
  assign tdec     = (tapt_r != '0) ? tapt_r - 1'b1 : tapt_r;
  assign arow     = rd_data[5:3];
  assign abit     = rd_data[2:0];
  assign adown    = !rd_data[6];
  assign awas     = rows_r[arow][abit];
  assign out_free = !ov_r || out_ready;
  assign take     = (st_r == S_IDLE) && item_vld;

  assign out_valid          = ov_r;
  assign out_read_data      = ord_r;
  assign out_keypress_level = okp_r;
  assign stat.idle          = (st_r == S_IDLE);
  assign stat.count         = cnt_r;

  always_comb begin
    rdv = 8'd0;
    for (int r = 0; r < 7; r++) begin
      if (itm_r.addr[r]) rdv = rdv | rows_r[r];
    end
    if (itm_r.addr[7]) rdv = rdv | force_row7(force_row7(rows_r[7], sfm_r), tapm_r);
    if (tapv_r && itm_r.addr[tapk_r[5:3]]) rdv[tapk_r[2:0]] = 1'b1;
    if (itm_r.cmd != CMD_READ) rdv = 8'd0;
  end

  always_comb begin
    st_nxt   = st_r;
    itm_nxt  = itm_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    rows_nxt = rows_r;
    sfm_nxt  = sfm_r;
    prs_nxt  = prs_r;
    tick_nxt = tick_r;
    dl_nxt   = dl_r;
    tapv_nxt = tapv_r;
    tapk_nxt = tapk_r;
    tapm_nxt = tapm_r;
    tapt_nxt = tapt_r;
    last_nxt = last_r;
    kp_nxt   = kp_r;
    a2_nxt   = a2_r;
    wr_en    = 1'b0;
    wr_data  = '0;
    rd_en    = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (item_vld) begin
          itm_nxt = item;
          st_nxt  = S_DONE;
          case (item.cmd)
            CMD_KEY: begin
              if (item.code == 8'd0 && item.rel) begin
                wr_en    = 1'b1;
                wr_data  = {1'b0, K_ALLUP, 7'd0};
                last_nxt = M_NEUTRAL;
              end else if (item.mapped) begin
                wr_en = 1'b1;
                if (!item.rel) begin
                  if (last_r != M_PERSIST && last_r != item.mode) begin
                    last_nxt = item.mode;
                    wr_data  = {1'b0, K_MODE, 5'd0, item.mode};
                    a2_nxt   = {1'b0, K_KEY, 1'b0, item.key};
                    st_nxt   = S_ENQ2;
                  end else begin
                    wr_data = {1'b0, K_KEY, 1'b0, item.key};
                  end
                end else begin
                  wr_data = {1'b0, K_KEY, 1'b1, item.key};
                  if (last_r != M_NEUTRAL && last_r == item.mode) begin
                    last_nxt = M_NEUTRAL;
                    a2_nxt   = {1'b0, K_MODE, 5'd0, M_NEUTRAL};
                    st_nxt   = S_ENQ2;
                  end
                end
              end
            end
            CMD_TAP: begin
              if (item.mapped) begin
                tapv_nxt = 1'b1;
                tapk_nxt = item.key;
                tapm_nxt = item.mode;
                tapt_nxt = TAP_W'(TAP_TICKS);
                kp_nxt   = lvl;
              end
            end
            CMD_TICK: begin
              if (tick_r != 2'd3) tick_nxt = tick_r + 1'b1;
              if (tapv_r) begin
                tapt_nxt = tdec;
                if (tdec == '0) begin
                  tapv_nxt = 1'b0;
                  tapm_nxt = M_NEUTRAL;
                  kp_nxt   = 8'd0;
                end else begin
                  kp_nxt = lvl;
                end
              end
            end
            CMD_READ: st_nxt = (tick_r > 2'd2) ? S_DRAIN : S_DL;
            CMD_CLEAR: begin
              head_nxt = '0;
              cnt_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_ENQ2: begin
        wr_en   = 1'b1;
        wr_data = a2_r;
        st_nxt  = S_DONE;
      end
      S_DRAIN: begin
        rd_en = (cnt_r != '0);
        if (cnt_r == '0 && !pend_r) st_nxt = S_DL;
      end
      S_DL: begin
        if (diff[CYC_W-1]) begin
          dl_nxt = cyc + CYC_W'(stretch);
          rd_en  = (cnt_r != '0);
        end
        st_nxt = S_WAIT;
      end
      S_WAIT: st_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          st_nxt = S_IDLE;
          if (itm_r.cmd == CMD_READ) tick_nxt = 2'd0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (wr_en && cnt_r < CNT_W'(QUEUE_DEPTH)) cnt_nxt = cnt_r + 1'b1;
    if (rd_en) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - 1'b1;
    end

    if (pend_r) begin
      case (rd_data[8:7])
        K_ALLUP: begin
          for (int r = 0; r < 8; r++) rows_nxt[r] = 8'd0;
          sfm_nxt = M_NEUTRAL;
          prs_nxt = 7'd0;
          kp_nxt  = 8'd0;
        end
        K_MODE: sfm_nxt = rd_data[1:0];
        K_KEY: begin
          if (adown != awas) begin
            rows_nxt[arow][abit] = adown;
            prs_nxt = adown ? prs_r + 1'b1 : prs_r - 1'b1;
            kp_nxt  = (prs_nxt != 7'd0) ? 8'd1 : 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      head_r <= '0;
      cnt_r  <= '0;
      for (int r = 0; r < 8; r++) rows_r[r] <= 8'd0;
      sfm_r  <= M_NEUTRAL;
      prs_r  <= 7'd0;
      tick_r <= 2'd0;
      dl_r   <= '0;
      tapv_r <= 1'b0;
      tapm_r <= M_NEUTRAL;
      tapt_r <= '0;
      last_r <= M_NEUTRAL;
      kp_r   <= 8'd0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      rows_r <= rows_nxt;
      sfm_r  <= sfm_nxt;
      prs_r  <= prs_nxt;
      tick_r <= tick_nxt;
      dl_r   <= dl_nxt;
      tapv_r <= tapv_nxt;
      tapm_r <= tapm_nxt;
      tapt_r <= tapt_nxt;
      last_r <= last_nxt;
      kp_r   <= kp_nxt;
      pend_r <= rd_en;
      if (st_r == S_DONE && out_free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    itm_r  <= itm_nxt;
    tapk_r <= tapk_nxt;
    a2_r   <= a2_nxt;
    if (st_r == S_DONE && out_free) begin
      ord_r <= rdv;
      okp_r <= kp_r;
    end
  end

endmodule

// ===== sv/keyboard_matrix_event_queue_unit.sv =====
// Top level of the keyboard matrix event queue: configuration registers, front and back.
// Depends on kmeq_pkg, kmeq_front, kmeq_back and the assertion macro header.
// One item is in work at a time. Key change, tap, tick and clear items pass from the
// idle state to the done state, through the second enqueue state when a key change also
// queues a shift-mode action. A read passes through the deadline and wait states before
// the done state; when more than two ticks have passed it first drains the queue, which
// pops the action queue once a cycle until it is empty. The input stage takes the next
// item while the current one is in work, and the result register holds until taken.
`include "keyboard_matrix_event_queue_unit_macros.svh"
module keyboard_matrix_event_queue_unit import kmeq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic        in_key_released,
  input  logic [7:0]  in_read_address,
  input  logic [31:0] in_cycle_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_keypress_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] stretch_r;
  logic [7:0]  turbo_r;
  logic        item_vld, take;
  item_t       item;
  bk_stat_t    stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stretch_r <= 32'd4000;
      turbo_r   <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_STRETCH) stretch_r <= cfg_wdata;
      if (cfg_index == REG_TURBO) turbo_r <= cfg_wdata[7:0];
    end
  end

  kmeq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_key_released (in_key_released),
    .in_read_address (in_read_address),
    .in_cycle_count  (in_cycle_count),
    .take            (take),
    .item_vld        (item_vld),
    .item            (item)
  );

  kmeq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_vld           (item_vld),
    .item               (item),
    .take               (take),
    .stretch            (stretch_r),
    .turbo              (turbo_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_keypress_level (out_keypress_level),
    .stat               (stat)
  );

  `KMEQ_NEVER(a_cnt_bound, stat.count > CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `KMEQ_ASSERT(a_take_idle, take |=> !stat.idle, "back took an item but stayed idle")
  `KMEQ_ASSERT(a_ready_empty, !item_vld |-> in_ready, "input stage empty but not ready")

endmodule
